[rtl/core/efr_pkg.sv]
// Shared types, constants and tables for the earth frame rotation block.
package efr_pkg;

    localparam int ANGLE_BITS_DEF = 32;
    localparam int CORDIC_STEPS   = 30;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_TURN_RATE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_RATE = 8'd1;

    localparam logic [47:0] TURN_RATE_RST = 48'd836283360000;
    localparam logic [31:0] SPIN_RATE_RST = 32'd80177659;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic               operation;
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic signed [47:0] pos_z;
        logic signed [39:0] vel_x;
        logic signed [39:0] vel_y;
        logic signed [39:0] vel_z;
    } efr_item_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic signed [33:0] atan_turn(input int idx);
        logic signed [33:0] r;
        case (idx)
            0:  r = 34'sd536870912;
            1:  r = 34'sd316933406;
            2:  r = 34'sd167458907;
            3:  r = 34'sd85004756;
            4:  r = 34'sd42667331;
            5:  r = 34'sd21354465;
            6:  r = 34'sd10679838;
            7:  r = 34'sd5340245;
            8:  r = 34'sd2670163;
            9:  r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            24: r = 34'sd41;
            25: r = 34'sd20;
            26: r = 34'sd10;
            27: r = 34'sd5;
            28: r = 34'sd3;
            29: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/efr_angle.sv]
// Earth angle: turn rate times elapsed time, split multiply over two stages.
module efr_angle #(
    parameter int ANGLE_BITS = efr_pkg::ANGLE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  efr_pkg::efr_item_t in_item,
    input  logic [39:0]       elapsed_time,
    input  logic [47:0]       turn_rate,
    output logic              out_valid,
    output efr_pkg::efr_item_t out_item,
    output logic [31:0]       out_angle
);
    import efr_pkg::*;

    localparam int KEEP = (ANGLE_BITS >= 32) ? 32 : ANGLE_BITS;
    localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - KEEP)) - 32'd1);

    logic [67:0] p_lo_reg, p_hi_reg;
    efr_item_t   it1_reg, it2_reg;
    logic [1:0]  vld_reg;
    logic [31:0] angle_reg;
    logic [65:0] sum_next;

    assign sum_next = p_lo_reg[65:0] + {p_hi_reg[45:0], 20'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_lo_reg  <= 68'(turn_rate) * 68'(elapsed_time[19:0]);
            p_hi_reg  <= 68'(turn_rate) * 68'(elapsed_time[39:20]);
            it1_reg   <= in_item;
            angle_reg <= sum_next[65:34] & ANGLE_MASK;
            it2_reg   <= it1_reg;
        end
    end

    assign out_valid = vld_reg[1];
    assign out_item  = it2_reg;
    assign out_angle = angle_reg;
endmodule

[rtl/core/efr_cordic.sv]
// Pipelined CORDIC giving cosine and signed sine of the earth angle, Q30.
module efr_cordic (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  efr_pkg::efr_item_t in_item,
    input  logic [31:0]       in_angle,
    output logic              out_valid,
    output efr_pkg::efr_item_t out_item,
    output logic signed [33:0] out_cos,
    output logic signed [33:0] out_sin
);
    import efr_pkg::*;

    logic signed [33:0] x_reg [CORDIC_STEPS];
    logic signed [33:0] y_reg [CORDIC_STEPS];
    logic signed [33:0] z_reg [CORDIC_STEPS];
    logic [1:0]         q_reg [CORDIC_STEPS];
    efr_item_t          it_reg [CORDIC_STEPS];
    logic [CORDIC_STEPS-1:0] vld_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [33:0] xp, yp, zp;
        logic [1:0]         qp;
        efr_item_t          ip;
        logic               vp;

        if (i == 0)
        begin : g_first
            assign xp = CORDIC_GAIN;
            assign yp = '0;
            assign zp = $signed({4'd0, in_angle[29:0]});
            assign qp = in_angle[31:30];
            assign ip = in_item;
            assign vp = in_valid;
        end
        else
        begin : g_rest
            assign xp = x_reg[i-1];
            assign yp = y_reg[i-1];
            assign zp = z_reg[i-1];
            assign qp = q_reg[i-1];
            assign ip = it_reg[i-1];
            assign vp = vld_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= vp;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!zp[33])
                begin
                    x_reg[i] <= xp - (yp >>> i);
                    y_reg[i] <= yp + (xp >>> i);
                    z_reg[i] <= zp - atan_turn(i);
                end
                else
                begin
                    x_reg[i] <= xp + (yp >>> i);
                    y_reg[i] <= yp - (xp >>> i);
                    z_reg[i] <= zp + atan_turn(i);
                end
                q_reg[i]  <= qp;
                it_reg[i] <= ip;
            end
        end
    end

    logic signed [33:0] c_next, s_next, xl, yl;
    logic signed [33:0] c_reg, s_reg;
    efr_item_t          ito_reg;
    logic               vo_reg;

    assign xl = x_reg[CORDIC_STEPS-1];
    assign yl = y_reg[CORDIC_STEPS-1];

    always_comb
    begin
        case (q_reg[CORDIC_STEPS-1])
            2'd0:
            begin
                c_next = xl;
                s_next = yl;
            end
            2'd1:
            begin
                c_next = -yl;
                s_next = xl;
            end
            2'd2:
            begin
                c_next = -xl;
                s_next = -yl;
            end
            default:
            begin
                c_next = yl;
                s_next = -xl;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= vld_reg[CORDIC_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg   <= c_next;
            // inverse rotation runs with the negated sine
            s_reg   <= it_reg[CORDIC_STEPS-1].operation ? -s_next : s_next;
            ito_reg <= it_reg[CORDIC_STEPS-1];
        end
    end

    assign out_valid = vo_reg;
    assign out_item  = ito_reg;
    assign out_cos   = c_reg;
    assign out_sin   = s_reg;
endmodule

[rtl/core/efr_rotate.sv]
// Cross term, rotation of position and velocity, rounding and saturation.
module efr_rotate (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  efr_pkg::efr_item_t  in_item,
    input  logic signed [33:0] in_cos,
    input  logic signed [33:0] in_sin,
    input  logic [31:0]        spin_rate,
    output logic               out_valid,
    output logic signed [47:0] out_pos_x,
    output logic signed [47:0] out_pos_y,
    output logic signed [47:0] out_pos_z,
    output logic signed [39:0] out_vel_x,
    output logic signed [39:0] out_vel_y,
    output logic signed [39:0] out_vel_z
);
    import efr_pkg::*;

    function automatic logic signed [58:0] mul_lo(input logic [23:0] a,
                                                  input logic signed [33:0] b);
        mul_lo = $signed({1'b0, a}) * b;
    endfunction

    function automatic logic signed [57:0] mul_hi(input logic signed [23:0] a,
                                                  input logic signed [33:0] b);
        mul_hi = a * b;
    endfunction

    function automatic logic signed [81:0] join_p(input logic signed [57:0] hi,
                                                  input logic signed [58:0] lo);
        join_p = $signed({hi, 24'd0}) + 82'(lo);
    endfunction

    function automatic logic signed [63:0] vmul_lo(input logic [28:0] a,
                                                   input logic signed [33:0] b);
        vmul_lo = $signed({1'b0, a}) * b;
    endfunction

    function automatic logic signed [62:0] vmul_hi(input logic signed [28:0] a,
                                                   input logic signed [33:0] b);
        vmul_hi = a * b;
    endfunction

    function automatic logic signed [91:0] join_v(input logic signed [62:0] hi,
                                                  input logic signed [63:0] lo);
        join_v = $signed({hi, 29'd0}) + 92'(lo);
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [53:0] v);
        if (v > 54'sd140737488355327)
            sat48 = 48'sd140737488355327;
        else if (v < -54'sd140737488355328)
            sat48 = -48'sd140737488355328;
        else
            sat48 = v[47:0];
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [47:0] v);
        if (v > 48'sd549755813887)
            sat40 = 40'sd549755813887;
        else if (v < -48'sd549755813888)
            sat40 = -40'sd549755813888;
        else
            sat40 = v[39:0];
    endfunction

    logic [7:0] vld_reg;
    efr_item_t  it1_reg, it2_reg, it3_reg, it4_reg, it5_reg, it6_reg, it7_reg;
    logic signed [33:0] c1_reg, s1_reg, c2_reg, s2_reg, c3_reg, s3_reg, c4_reg, s4_reg;
    logic signed [33:0] wb;

    assign wb = $signed({2'b00, spin_rate});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[6:0], in_valid};
    end

    // stage 1: partial products
    logic signed [58:0] xc_lo_reg, ys_lo_reg, xs_lo_reg, yc_lo_reg, wy_lo_reg, wx_lo_reg;
    logic signed [57:0] xc_hi_reg, ys_hi_reg, xs_hi_reg, yc_hi_reg, wy_hi_reg, wx_hi_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xc_lo_reg <= mul_lo(in_item.pos_x[23:0], in_cos);
            xc_hi_reg <= mul_hi($signed(in_item.pos_x[47:24]), in_cos);
            ys_lo_reg <= mul_lo(in_item.pos_y[23:0], in_sin);
            ys_hi_reg <= mul_hi($signed(in_item.pos_y[47:24]), in_sin);
            xs_lo_reg <= mul_lo(in_item.pos_x[23:0], in_sin);
            xs_hi_reg <= mul_hi($signed(in_item.pos_x[47:24]), in_sin);
            yc_lo_reg <= mul_lo(in_item.pos_y[23:0], in_cos);
            yc_hi_reg <= mul_hi($signed(in_item.pos_y[47:24]), in_cos);
            wy_lo_reg <= mul_lo(in_item.pos_y[23:0], wb);
            wy_hi_reg <= mul_hi($signed(in_item.pos_y[47:24]), wb);
            wx_lo_reg <= mul_lo(in_item.pos_x[23:0], wb);
            wx_hi_reg <= mul_hi($signed(in_item.pos_x[47:24]), wb);
            c1_reg    <= in_cos;
            s1_reg    <= in_sin;
            it1_reg   <= in_item;
        end
    end

    // stage 2: full products
    logic signed [81:0] f_xc_reg, f_ys_reg, f_xs_reg, f_yc_reg, f_wy_reg, f_wx_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_xc_reg <= join_p(xc_hi_reg, xc_lo_reg);
            f_ys_reg <= join_p(ys_hi_reg, ys_lo_reg);
            f_xs_reg <= join_p(xs_hi_reg, xs_lo_reg);
            f_yc_reg <= join_p(yc_hi_reg, yc_lo_reg);
            f_wy_reg <= join_p(wy_hi_reg, wy_lo_reg);
            f_wx_reg <= join_p(wx_hi_reg, wx_lo_reg);
            c2_reg   <= c1_reg;
            s2_reg   <= s1_reg;
            it2_reg  <= it1_reg;
        end
    end

    // stage 3: position sums, cross term rounded to Q16
    logic signed [82:0] sp_x_reg, sp_y_reg;
    logic signed [57:0] crx_reg, cry_reg;
    logic signed [82:0] nwy, rwy, rwx;
    logic signed [57:0] crx_t, cry_t, crx_next, cry_next;

    always_comb
    begin
        nwy   = -83'(f_wy_reg);
        rwy   = (nwy + 83'sd8388608) >>> 24;
        rwx   = (83'(f_wx_reg) + 83'sd8388608) >>> 24;
        crx_t = $signed(rwy[57:0]);
        cry_t = $signed(rwx[57:0]);
        crx_next = it2_reg.operation ? -crx_t : crx_t;
        cry_next = it2_reg.operation ? -cry_t : cry_t;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp_x_reg <= 83'(f_xc_reg) - 83'(f_ys_reg);
            sp_y_reg <= 83'(f_xs_reg) + 83'(f_yc_reg);
            crx_reg  <= crx_next;
            cry_reg  <= cry_next;
            c3_reg   <= c2_reg;
            s3_reg   <= s2_reg;
            it3_reg  <= it2_reg;
        end
    end

    // stage 4: position rounding, velocity plus cross term
    logic signed [83:0] rp_x_full, rp_y_full;
    logic signed [53:0] rp_x_reg, rp_y_reg;
    logic signed [57:0] ux_reg, uy_reg;

    assign rp_x_full = (84'(sp_x_reg) + 84'sd536870912) >>> 30;
    assign rp_y_full = (84'(sp_y_reg) + 84'sd536870912) >>> 30;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rp_x_reg <= rp_x_full[53:0];
            rp_y_reg <= rp_y_full[53:0];
            ux_reg   <= (58'(it3_reg.vel_x) <<< 16) + crx_reg;
            uy_reg   <= (58'(it3_reg.vel_y) <<< 16) + cry_reg;
            c4_reg   <= c3_reg;
            s4_reg   <= s3_reg;
            it4_reg  <= it3_reg;
        end
    end

    // stage 5: position saturation, velocity partial products
    logic signed [47:0] p5_x_reg, p5_y_reg, p6_x_reg, p6_y_reg, p7_x_reg, p7_y_reg;
    logic signed [63:0] uxc_lo_reg, uxs_lo_reg, uyc_lo_reg, uys_lo_reg;
    logic signed [62:0] uxc_hi_reg, uxs_hi_reg, uyc_hi_reg, uys_hi_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p5_x_reg   <= sat48(rp_x_reg);
            p5_y_reg   <= sat48(rp_y_reg);
            uxc_lo_reg <= vmul_lo(ux_reg[28:0], c4_reg);
            uxc_hi_reg <= vmul_hi($signed(ux_reg[57:29]), c4_reg);
            uxs_lo_reg <= vmul_lo(ux_reg[28:0], s4_reg);
            uxs_hi_reg <= vmul_hi($signed(ux_reg[57:29]), s4_reg);
            uyc_lo_reg <= vmul_lo(uy_reg[28:0], c4_reg);
            uyc_hi_reg <= vmul_hi($signed(uy_reg[57:29]), c4_reg);
            uys_lo_reg <= vmul_lo(uy_reg[28:0], s4_reg);
            uys_hi_reg <= vmul_hi($signed(uy_reg[57:29]), s4_reg);
            it5_reg    <= it4_reg;
        end
    end

    // stage 6: full velocity products
    logic signed [91:0] f_uxc_reg, f_uxs_reg, f_uyc_reg, f_uys_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_uxc_reg <= join_v(uxc_hi_reg, uxc_lo_reg);
            f_uxs_reg <= join_v(uxs_hi_reg, uxs_lo_reg);
            f_uyc_reg <= join_v(uyc_hi_reg, uyc_lo_reg);
            f_uys_reg <= join_v(uys_hi_reg, uys_lo_reg);
            p6_x_reg  <= p5_x_reg;
            p6_y_reg  <= p5_y_reg;
            it6_reg   <= it5_reg;
        end
    end

    // stage 7: velocity sums
    logic signed [92:0] sv_x_reg, sv_y_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sv_x_reg <= 93'(f_uxc_reg) - 93'(f_uys_reg);
            sv_y_reg <= 93'(f_uxs_reg) + 93'(f_uyc_reg);
            p7_x_reg <= p6_x_reg;
            p7_y_reg <= p6_y_reg;
            it7_reg  <= it6_reg;
        end
    end

    // stage 8: velocity rounding and saturation, output register
    logic signed [93:0] rv_x_full, rv_y_full;
    logic signed [47:0] px_o_reg, py_o_reg, pz_o_reg;
    logic signed [39:0] vx_o_reg, vy_o_reg, vz_o_reg;

    assign rv_x_full = (94'(sv_x_reg) + 94'sd35184372088832) >>> 46;
    assign rv_y_full = (94'(sv_y_reg) + 94'sd35184372088832) >>> 46;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_o_reg <= p7_x_reg;
            py_o_reg <= p7_y_reg;
            pz_o_reg <= it7_reg.pos_z;
            vx_o_reg <= sat40($signed(rv_x_full[47:0]));
            vy_o_reg <= sat40($signed(rv_y_full[47:0]));
            vz_o_reg <= it7_reg.vel_z;
        end
    end

    assign out_valid = vld_reg[7];
    assign out_pos_x = px_o_reg;
    assign out_pos_y = py_o_reg;
    assign out_pos_z = pz_o_reg;
    assign out_vel_x = vx_o_reg;
    assign out_vel_y = vy_o_reg;
    assign out_vel_z = vz_o_reg;
endmodule

[rtl/core/earth_frame_rotation_top.sv]
// Top level of the earth frame rotation block.
// Accepts one item per clock and returns one result per item, in order. Each item
// passes through the split earth-angle multiply, the CORDIC (one stage per rotation
// step plus quadrant mapping) and the cross-term, rotation, rounding and saturation
// stages. The whole pipeline holds while a result waits at the output; in_ready is
// low only then. Configuration writes are always taken.
module earth_frame_rotation_top #(
    parameter int ANGLE_BITS = efr_pkg::ANGLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             operation,
    input  logic signed [47:0]               pos_x,
    input  logic signed [47:0]               pos_y,
    input  logic signed [47:0]               pos_z,
    input  logic signed [39:0]               vel_x,
    input  logic signed [39:0]               vel_y,
    input  logic signed [39:0]               vel_z,
    input  logic [39:0]                      elapsed_time,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [47:0]               out_pos_x,
    output logic signed [47:0]               out_pos_y,
    output logic signed [47:0]               out_pos_z,
    output logic signed [39:0]               out_vel_x,
    output logic signed [39:0]               out_vel_y,
    output logic signed [39:0]               out_vel_z,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [efr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [efr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import efr_pkg::*;

    logic [47:0] turn_rate_reg;
    logic [31:0] spin_rate_reg;
    logic        en;
    efr_item_t   item;
    logic        a_valid, c_valid;
    efr_item_t   a_item, c_item;
    logic [31:0] a_angle;
    logic signed [33:0] c_cos, c_sin;

    assign cfg_ready = 1'b1;
    assign en        = !out_valid || out_ready;
    assign in_ready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_rate_reg <= TURN_RATE_RST;
            spin_rate_reg <= SPIN_RATE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TURN_RATE: turn_rate_reg <= cfg_data[47:0];
                CFG_SPIN_RATE: spin_rate_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign item.operation = operation;
    assign item.pos_x     = pos_x;
    assign item.pos_y     = pos_y;
    assign item.pos_z     = pos_z;
    assign item.vel_x     = vel_x;
    assign item.vel_y     = vel_y;
    assign item.vel_z     = vel_z;

    efr_angle #(.ANGLE_BITS(ANGLE_BITS)) u_angle (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (in_valid),
        .in_item      (item),
        .elapsed_time (elapsed_time),
        .turn_rate    (turn_rate_reg),
        .out_valid    (a_valid),
        .out_item     (a_item),
        .out_angle    (a_angle)
    );

    efr_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a_valid),
        .in_item   (a_item),
        .in_angle  (a_angle),
        .out_valid (c_valid),
        .out_item  (c_item),
        .out_cos   (c_cos),
        .out_sin   (c_sin)
    );

    efr_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid),
        .in_item   (c_item),
        .in_cos    (c_cos),
        .in_sin    (c_sin),
        .spin_rate (spin_rate_reg),
        .out_valid (out_valid),
        .out_pos_x (out_pos_x),
        .out_pos_y (out_pos_y),
        .out_pos_z (out_pos_z),
        .out_vel_x (out_vel_x),
        .out_vel_y (out_vel_y),
        .out_vel_z (out_vel_z)
    );
endmodule

[rtl/core/efr_checker.sv]
// Port-level checker for the earth frame rotation block, with its bind.
module efr_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [47:0] out_pos_x,
    input logic [39:0] out_vel_x,
    input logic        cfg_valid,
    input logic        cfg_ready
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_pos_x) && $stable(out_vel_x))
        else $error("result changed while stalled");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");
endmodule

bind earth_frame_rotation_top efr_port_checks u_efr_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pos_x (out_pos_x),
    .out_vel_x (out_vel_x),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
